// File: src/ambient_light_lux_conversion_macros.svh
// ---------------------------------------------------------------------------
// Ambient light lux conversion: assertion macros
// Simulation-only property checks; they expand to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef AMBIENT_LIGHT_LUX_CONVERSION_MACROS_SVH
`define AMBIENT_LIGHT_LUX_CONVERSION_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define ALC_ASSERT_HOLD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define ALC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ALC_ASSERT_HOLD(label, clk, rst_n, prop, msg)
`define ALC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/alc_pkg.sv
// ---------------------------------------------------------------------------
// Ambient light lux conversion: shared package
// Field widths, register codes and the fixed-point constants of the
// scaling and correction datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package alc_pkg;

  // Port widths
  localparam int RAW_W      = 16;
  localparam int LUX_W      = 35;
  localparam int GAIN_W     = 2;
  localparam int INTEG_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG = 1'd1;

  // Gain codes
  localparam logic [GAIN_W-1:0] GAIN_X1   = 2'd0;
  localparam logic [GAIN_W-1:0] GAIN_X2   = 2'd1;
  localparam logic [GAIN_W-1:0] GAIN_DIV8 = 2'd2;
  localparam logic [GAIN_W-1:0] GAIN_DIV4 = 2'd3;

  // Integration time codes
  localparam logic [INTEG_W-1:0] INTEG_25MS  = 3'd0;
  localparam logic [INTEG_W-1:0] INTEG_100MS = 3'd2;
  localparam logic [INTEG_W-1:0] INTEG_800MS = 3'd5;

  // Correction applies above this raw count
  localparam logic [RAW_W-1:0] CORR_MIN = 16'd100;

  // Pipeline depths
  localparam int MUL_LAT   = 3;
  localparam int SCALE_LAT = 6;

  // Scaled count N = raw * 9 * 2^(gain shift + integration shift)
  localparam int SH_W   = 4;
  localparam int RAW9_W = 20;
  localparam int N_W    = 29;

  // Lq = floor(N * 2^32 / 2500) = floor(N * 2^30 / 625), Q32
  localparam int LQ_W    = 49;
  localparam int LQ_FRAC = 32;
  localparam int LQ_Q_SH = 30;
  localparam int R_W     = 10;
  localparam logic [63:0] DIV_K64 = 64'd625;
  localparam logic [R_W-1:0] DIV_K = DIV_K64[R_W-1:0];

  // N / 625 by reciprocal; exact since N * (rounding error) < 2^RN_SH
  localparam int RN_SH = 39;
  localparam int RN_W  = 30;
  localparam logic [63:0] RN64 = ((64'd1 << RN_SH) + DIV_K64 - 64'd1) / DIV_K64;
  localparam logic [RN_W-1:0] RECIP_N = RN64[RN_W-1:0];
  localparam int QP_W = N_W + RN_W;
  localparam int Q_W  = QP_W - RN_SH;

  // floor(r * 2^30 / 625) = r * FRAC_Q + floor(r * FRAC_R / 625)
  localparam int FRAC_Q_W = 21;
  localparam logic [63:0] FQ64 = (64'd1 << LQ_Q_SH) / DIV_K64;
  localparam logic [63:0] FR64 = (64'd1 << LQ_Q_SH) % DIV_K64;
  localparam logic [FRAC_Q_W-1:0] FRAC_Q = FQ64[FRAC_Q_W-1:0];
  localparam logic [R_W-1:0]      FRAC_R = FR64[R_W-1:0];
  localparam int IP_W = R_W + FRAC_Q_W;
  localparam int Y_W  = 19;

  // y / 625 by reciprocal; exact for y < 2^Y_W
  localparam int RY_SH = 29;
  localparam int RY_W  = 20;
  localparam logic [63:0] RY64 = ((64'd1 << RY_SH) + DIV_K64 - 64'd1) / DIV_K64;
  localparam logic [RY_W-1:0] RECIP_Y = RY64[RY_W-1:0];
  localparam int YP_W = Y_W + RY_W;

  // Polynomial coefficients: c4 Q80, |c3| Q64, c2 Q64, c1 Q40
  localparam int C4_W  = 40;
  localparam int C3_W  = 38;
  localparam int T_SH  = 48;
  localparam int T_W   = LQ_W + C4_W - T_SH;
  localparam int NG_SH = 32;
  localparam int NG_W  = LQ_W + C3_W - NG_SH;
  localparam int X_SH  = 32;
  localparam int B_W   = LQ_W + T_W - X_SH + 1;
  localparam int C_SH  = 56;
  localparam int C_W   = LQ_W + B_W - C_SH;
  localparam int RES_BASE = 72;

  localparam logic [C4_W-1:0] Q_C4 = 40'd726987541625;
  localparam logic [C3_W-1:0] Q_C3 = 38'd173259199037;
  localparam logic [B_W-1:0]  Q_C2 = 59'd1503188281078444;
  localparam logic [C_W-1:0]  Q_C1 = 52'd1102040504520;

  // Configuration bundle
  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [INTEG_W-1:0] integ;
  } alc_cfg_t;

  // Gain factor times two is a power of two: x2, x1, x16, x8
  function automatic logic [SH_W-1:0] gain_shift(input logic [GAIN_W-1:0] code);
    logic [SH_W-1:0] sh;
    unique case (code)
      GAIN_X1:   sh = SH_W'(1);
      GAIN_X2:   sh = SH_W'(0);
      GAIN_DIV8: sh = SH_W'(4);
      GAIN_DIV4: sh = SH_W'(3);
      default:   sh = SH_W'(0);
    endcase
    return sh;
  endfunction

  // Shorter integration doubles the factor; undefined codes act as 25 ms
  function automatic logic [SH_W-1:0] integ_shift(input logic [INTEG_W-1:0] code);
    logic [SH_W-1:0] sh;
    if (code <= INTEG_800MS) begin
      sh = SH_W'(INTEG_800MS - code);
    end else begin
      sh = SH_W'(INTEG_800MS - INTEG_25MS);
    end
    return sh;
  endfunction

endpackage

`default_nettype wire

// File: src/alc_mul.sv
// ---------------------------------------------------------------------------
// Ambient light lux conversion: pipelined wide multiplier
// Splits each operand in halves: partial products, cross-term sum, final sum.
// ---------------------------------------------------------------------------
`default_nettype none

module alc_mul
  import alc_pkg::*;
#(
  parameter int A_W = 32,
  parameter int B_W = 32
) (
  input  logic                 clk,
  input  logic [MUL_LAT-1:0]   en_i,
  input  logic [A_W-1:0]       a_i,
  input  logic [B_W-1:0]       b_i,
  output logic [A_W+B_W-1:0]   p_o
);

  localparam int AL  = (A_W + 1) / 2;
  localparam int AH  = A_W - AL;
  localparam int BL  = (B_W + 1) / 2;
  localparam int BH  = B_W - BL;
  localparam int P_W = A_W + B_W;

  logic [AL+BL-1:0] pll_nxt, pll_r;
  logic [AL+BH-1:0] plh_nxt, plh_r;
  logic [AH+BL-1:0] phl_nxt, phl_r;
  logic [AH+BH-1:0] phh_nxt, phh_r;
  logic [P_W-1:0]   mid_nxt, mid_r;
  logic [P_W-1:0]   hl_r;
  logic [P_W-1:0]   p_nxt, p_r;

  // Stage 1: four half-width partial products
  assign pll_nxt = (AL+BL)'(a_i[AL-1:0])   * (AL+BL)'(b_i[BL-1:0]);
  assign plh_nxt = (AL+BH)'(a_i[AL-1:0])   * (AL+BH)'(b_i[B_W-1:BL]);
  assign phl_nxt = (AH+BL)'(a_i[A_W-1:AL]) * (AH+BL)'(b_i[BL-1:0]);
  assign phh_nxt = (AH+BH)'(a_i[A_W-1:AL]) * (AH+BH)'(b_i[B_W-1:BL]);

  // Stage 2: cross terms summed; outer terms just concatenate
  assign mid_nxt = (P_W'(plh_r) << BL) + (P_W'(phl_r) << AL);

  // Stage 3: full product
  assign p_nxt = hl_r + mid_r;

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      pll_r <= pll_nxt;
      plh_r <= plh_nxt;
      phl_r <= phl_nxt;
      phh_r <= phh_nxt;
    end
    if (en_i[1]) begin
      mid_r <= mid_nxt;
      hl_r  <= {phh_r, pll_r};
    end
    if (en_i[2]) begin
      p_r <= p_nxt;
    end
  end

  assign p_o = p_r;

endmodule

`default_nettype wire

// File: src/alc_scale.sv
// ---------------------------------------------------------------------------
// Ambient light lux conversion: count scaling
// Scales the raw count by gain and integration time and divides by 2500
// exactly, giving base illuminance in Q32 plus the correction flag.
// ---------------------------------------------------------------------------
`default_nettype none

module alc_scale
  import alc_pkg::*;
(
  input  logic                 clk,
  input  logic [SCALE_LAT-1:0] en_i,
  input  alc_cfg_t             cfg_i,
  input  logic [RAW_W-1:0]     raw_i,
  output logic [LQ_W-1:0]      lq_o,
  output logic                 corr_o
);

  logic [RAW9_W-1:0]    raw9;
  logic [SH_W-1:0]      sh;
  logic [N_W-1:0]       n0_nxt, n0_r;
  logic [SCALE_LAT-1:0] cr_r;
  logic [QP_W-1:0]      qp1_nxt, qp1_r;
  logic [N_W-1:0]       n1_r;
  logic [Q_W-1:0]       q1;
  logic [N_W-1:0]       q625;
  logic [N_W-1:0]       rem;
  logic [Q_W-1:0]       q2_r, q3_r, q4_r;
  logic [R_W-1:0]       r2_r;
  logic [IP_W-1:0]      ip3_nxt, ip3_r, ip4_r;
  logic [Y_W-1:0]       y3_nxt, y3_r;
  logic [YP_W-1:0]      yp4_nxt, yp4_r;
  logic [LQ_W-1:0]      lq5_nxt, lq5_r;

  // Stage 0: raw * 9, then power-of-two gain and integration factors
  assign raw9   = RAW9_W'({raw_i, 3'b000}) + RAW9_W'(raw_i);
  assign sh     = gain_shift(cfg_i.gain) + integ_shift(cfg_i.integ);
  assign n0_nxt = N_W'(raw9) << sh;

  // Stage 1: quotient by 625 via reciprocal
  assign qp1_nxt = QP_W'(n0_r) * QP_W'(RECIP_N);

  // Stage 2: quotient and remainder
  assign q1   = qp1_r[QP_W-1:RN_SH];
  assign q625 = N_W'(q1) * N_W'(DIV_K);
  assign rem  = n1_r - q625;

  // Stage 3: fraction of remainder, integer part and leftover
  assign ip3_nxt = IP_W'(r2_r) * IP_W'(FRAC_Q);
  assign y3_nxt  = Y_W'(r2_r) * Y_W'(FRAC_R);

  // Stage 4: leftover / 625 via reciprocal
  assign yp4_nxt = YP_W'(y3_r) * YP_W'(RECIP_Y);

  // Stage 5: assemble Q32 value
  assign lq5_nxt = LQ_W'({q4_r, {LQ_Q_SH{1'b0}}}) + LQ_W'(ip4_r)
                 + LQ_W'(yp4_r[YP_W-1:RY_SH]);

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      n0_r    <= n0_nxt;
      cr_r[0] <= (raw_i > CORR_MIN);
    end
    if (en_i[1]) begin
      qp1_r   <= qp1_nxt;
      n1_r    <= n0_r;
      cr_r[1] <= cr_r[0];
    end
    if (en_i[2]) begin
      q2_r    <= q1;
      r2_r    <= rem[R_W-1:0];
      cr_r[2] <= cr_r[1];
    end
    if (en_i[3]) begin
      ip3_r   <= ip3_nxt;
      y3_r    <= y3_nxt;
      q3_r    <= q2_r;
      cr_r[3] <= cr_r[2];
    end
    if (en_i[4]) begin
      yp4_r   <= yp4_nxt;
      ip4_r   <= ip3_r;
      q4_r    <= q3_r;
      cr_r[4] <= cr_r[3];
    end
    if (en_i[5]) begin
      lq5_r   <= lq5_nxt;
      cr_r[5] <= cr_r[4];
    end
  end

  assign lq_o   = lq5_r;
  assign corr_o = cr_r[SCALE_LAT-1];

endmodule

`default_nettype wire

// File: src/ambient_light_lux_conversion.sv
// Pipeline: 22 register stages between an accepted input beat and its result.
// Throughput: one beat per cycle; bubbles collapse, and input stalls only once
// all 22 stages hold beats while the result waits.
// Reset (synchronous, rst_n low): all stage valid bits clear, gain returns to x1
// and integration time to 100 ms.
// ---------------------------------------------------------------------------
// Ambient light lux conversion: top level
// Raw count to lux (unsigned fixed point) with fourth-order Horner correction
// above a raw count of 100, as a fully pipelined datapath.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ambient_light_lux_conversion_macros.svh"

module ambient_light_lux_conversion
  import alc_pkg::*;
#(
  parameter int LUX_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [RAW_W-1:0]      in_raw_counts,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LUX_W-1:0]      out_lux_value,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Stage map
  localparam int S_LQ  = SCALE_LAT - 1;
  localparam int S_P1  = S_LQ + MUL_LAT;
  localparam int S_P3  = S_P1 + MUL_LAT;
  localparam int S_POS = S_P3 + 1;
  localparam int S_B   = S_POS + 1;
  localparam int S_P4  = S_B + MUL_LAT;
  localparam int S_C   = S_P4 + 1;
  localparam int S_P5  = S_C + MUL_LAT;
  localparam int S_OUT = S_P5 + 1;
  localparam int NSTG  = S_OUT + 1;

  localparam int P1_W = LQ_W + C4_W;
  localparam int P2_W = LQ_W + C3_W;
  localparam int P3_W = LQ_W + T_W;
  localparam int P4_W = LQ_W + B_W;
  localparam int P5_W = LQ_W + C_W;
  localparam int RSH  = RES_BASE - LUX_FRAC_BITS;
  localparam int USH  = LQ_FRAC - LUX_FRAC_BITS;

  logic [GAIN_W-1:0]  gain_r;
  logic [INTEG_W-1:0] integ_r;
  alc_cfg_t           cfg;

  logic [NSTG-1:0]    vld_nxt, vld_r;
  logic [NSTG-1:0]    en;

  logic [LQ_W-1:0]    lq_s;
  logic               corr_s;
  logic [LQ_W-1:0]    lqd_r [S_LQ+1:S_P5];
  logic               crd_r [S_LQ+1:S_P5];
  logic [NG_W-1:0]    ngd_r [S_P1+1:S_POS];

  logic [P1_W-1:0]    m1_p;
  logic [P2_W-1:0]    m2_p;
  logic [P3_W-1:0]    m3_p;
  logic [P4_W-1:0]    m4_p;
  logic [P5_W-1:0]    m5_p;

  logic [B_W-1:0]     pos_nxt, pos_r;
  logic [B_W-1:0]     negx;
  logic [B_W-1:0]     b_nxt, b_r;
  logic [C_W-1:0]     c_nxt, c_r;
  logic [P5_W-1:0]    p5_sh;
  logic [LQ_W-1:0]    lq_sh;
  logic [LUX_W-1:0]   res_nxt, res_r;

  // Configuration registers
  assign cfg_ready = 1'b1;
  assign cfg.gain  = gain_r;
  assign cfg.integ = integ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_X1;
      integ_r <= INTEG_100MS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN:  gain_r  <= cfg_data[GAIN_W-1:0];
        REG_INTEG: integ_r <= cfg_data[INTEG_W-1:0];
        default:   ;
      endcase
    end
  end

  // Stage enables: a stage moves when out_ready is high or when it or some later stage is empty
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = out_ready || (((~vld_r) >> k) != '0);
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];

  // Scaling and exact division by 2500
  alc_scale u_scale (
    .clk    (clk),
    .en_i   (en[S_LQ:0]),
    .cfg_i  (cfg),
    .raw_i  (in_raw_counts),
    .lq_o   (lq_s),
    .corr_o (corr_s)
  );

  // L * c4 and L * |c3| in parallel
  alc_mul #(.A_W(LQ_W), .B_W(C4_W)) u_mul_c4 (
    .clk  (clk),
    .en_i (en[S_P1:S_LQ+1]),
    .a_i  (lq_s),
    .b_i  (Q_C4),
    .p_o  (m1_p)
  );

  alc_mul #(.A_W(LQ_W), .B_W(C3_W)) u_mul_c3 (
    .clk  (clk),
    .en_i (en[S_P1:S_LQ+1]),
    .a_i  (lq_s),
    .b_i  (Q_C3),
    .p_o  (m2_p)
  );

  // L * t
  alc_mul #(.A_W(LQ_W), .B_W(T_W)) u_mul_t (
    .clk  (clk),
    .en_i (en[S_P3:S_P1+1]),
    .a_i  (lqd_r[S_P1]),
    .b_i  (m1_p[P1_W-1:T_SH]),
    .p_o  (m3_p)
  );

  // Second coefficient: c2 + L*t - L*|c3|, clamped at zero
  assign pos_nxt = Q_C2 + B_W'(m3_p[P3_W-1:X_SH]);
  assign negx    = B_W'(ngd_r[S_POS]);
  assign b_nxt   = (pos_r >= negx) ? (pos_r - negx) : '0;

  // L * b
  alc_mul #(.A_W(LQ_W), .B_W(B_W)) u_mul_b (
    .clk  (clk),
    .en_i (en[S_P4:S_B+1]),
    .a_i  (lqd_r[S_B]),
    .b_i  (b_r),
    .p_o  (m4_p)
  );

  assign c_nxt = Q_C1 + C_W'(m4_p[P4_W-1:C_SH]);

  // L * c
  alc_mul #(.A_W(LQ_W), .B_W(C_W)) u_mul_c (
    .clk  (clk),
    .en_i (en[S_P5:S_C+1]),
    .a_i  (lqd_r[S_C]),
    .b_i  (c_r),
    .p_o  (m5_p)
  );

  // Result select: corrected product or plain scaled value
  assign p5_sh   = m5_p >> RSH;
  assign lq_sh   = lqd_r[S_P5] >> USH;
  assign res_nxt = crd_r[S_P5] ? p5_sh[LUX_W-1:0] : lq_sh[LUX_W-1:0];

  // Datapath registers and delay lines
  always_ff @(posedge clk) begin
    if (en[S_LQ+1]) begin
      lqd_r[S_LQ+1] <= lq_s;
      crd_r[S_LQ+1] <= corr_s;
    end
    for (int k = S_LQ + 2; k <= S_P5; k++) begin
      if (en[k]) begin
        lqd_r[k] <= lqd_r[k-1];
        crd_r[k] <= crd_r[k-1];
      end
    end
    if (en[S_P1+1]) begin
      ngd_r[S_P1+1] <= m2_p[P2_W-1:NG_SH];
    end
    for (int k = S_P1 + 2; k <= S_POS; k++) begin
      if (en[k]) begin
        ngd_r[k] <= ngd_r[k-1];
      end
    end
    if (en[S_POS]) begin
      pos_r <= pos_nxt;
    end
    if (en[S_B]) begin
      b_r <= b_nxt;
    end
    if (en[S_C]) begin
      c_r <= c_nxt;
    end
    if (en[S_OUT]) begin
      res_r <= res_nxt;
    end
  end

  assign out_lux_value = res_r;

  // Checks
  `ALC_ASSERT_HOLD(a_empty_out_in_rdy, clk, rst_n, !out_valid |-> in_ready, "empty yet stalled")
  `ALC_ASSERT_HOLD(a_drain_in_rdy, clk, rst_n, out_ready |-> in_ready, "stalled while draining")
  `ALC_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")

endmodule

`default_nettype wire
